/* rtl/sdscan_pkg.sv */
// ----------------------------------------------------------------------------
// sdscan_pkg: shared types and helpers for the signed four-digit scan
// Frame layout, digit-info bundle, segment patterns and decade digit pick.
// ----------------------------------------------------------------------------
package sdscan_pkg;

    localparam logic [6:0] SEG_G      = 7'h40;
    localparam logic [6:0] SEG_BLANK  = 7'h00;
    localparam logic [9:0] DWELL_STD  = 10'd5;
    localparam logic [9:0] DWELL_LEAD = 10'd6;
    localparam logic [9:0] DWELL_TAIL = 10'd7;
    localparam logic [9:0] DWELL_BLINK = 10'd1000;

    localparam logic [3:0] EN_NONE = 4'h0;
    localparam logic [3:0] EN_D0   = 4'h1;
    localparam logic [3:0] EN_D1   = 4'h2;
    localparam logic [3:0] EN_D2   = 4'h4;
    localparam logic [3:0] EN_D3   = 4'h8;
    localparam logic [3:0] EN_ALL  = 4'hF;

    // Magnitudes at or above this no longer fit four digits.
    localparam logic [15:0] BIG_LIMIT = 16'd10000;

    localparam int          MAX_FRAMES = 5;
    localparam int          IDX_W      = $clog2(MAX_FRAMES + 1);

    typedef struct packed {
        logic [3:0] digit_enable;
        logic [6:0] segments;
        logic [9:0] dwell_ms;
    } t_frame;

    // Decoded value handed from the digit pipeline to the frame emitter.
    typedef struct packed {
        logic       neg;
        logic       big;
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } t_digits;

    function automatic logic [6:0] seg_pattern(input logic [3:0] d);
        logic [6:0] p;
        unique case (d)
            4'd0:    p = 7'h3F;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h27;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

    // Pick the decimal digit at one decade by parallel compares; unit is a
    // constant at every call, so each compare is against a fixed number.
    function automatic logic [3:0] dec_digit(input logic [13:0] v,
                                             input logic [13:0] unit);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 14'(k) * unit) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/sdscan_emit.sv */
// ----------------------------------------------------------------------------
// sdscan_emit: frame emitter
// Expands one decoded value into its 1 to 5 scan frames, one per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
module sdscan_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sdscan_pkg::t_digits i_digits,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output sdscan_pkg::t_frame  o_frame,
    output logic                o_last
);
    import sdscan_pkg::*;

    t_frame           r_frame [MAX_FRAMES];
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;

    t_frame           n_list  [MAX_FRAMES];
    t_frame           dfr     [4];
    t_frame           minus_fr;
    logic [IDX_W-1:0] ndig;
    logic [IDX_W-1:0] n_cnt;
    logic             out_take;
    logic             load;

    // Build the frame list for the incoming value.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dfr[k] = '{EN_NONE, SEG_BLANK, DWELL_STD};
        end
        minus_fr = '{EN_NONE, SEG_BLANK, DWELL_STD};
        if (i_digits.big) begin
            dfr[0] = '{EN_ALL, SEG_G, DWELL_BLINK};
            dfr[1] = '{EN_ALL, SEG_BLANK, DWELL_BLINK};
            ndig   = IDX_W'(2);
        end else if (i_digits.d3 != 4'd0) begin
            dfr[0] = '{EN_D3, seg_pattern(i_digits.d3), DWELL_STD};
            dfr[1] = '{EN_D2, seg_pattern(i_digits.d2), DWELL_STD};
            dfr[2] = '{EN_D1, seg_pattern(i_digits.d1), DWELL_STD};
            dfr[3] = '{EN_D0, seg_pattern(i_digits.d0), DWELL_STD};
            ndig   = IDX_W'(4);
        end else if (i_digits.d2 != 4'd0) begin
            dfr[0]   = '{EN_D2, seg_pattern(i_digits.d2), DWELL_LEAD};
            dfr[1]   = '{EN_D1, seg_pattern(i_digits.d1), DWELL_TAIL};
            dfr[2]   = '{EN_D0, seg_pattern(i_digits.d0), DWELL_TAIL};
            ndig     = IDX_W'(3);
            minus_fr = '{EN_D3, SEG_G, DWELL_STD};
        end else if (i_digits.d1 != 4'd0) begin
            dfr[0]   = '{EN_D1, seg_pattern(i_digits.d1), DWELL_STD};
            dfr[1]   = '{EN_D0, seg_pattern(i_digits.d0), DWELL_STD};
            ndig     = IDX_W'(2);
            minus_fr = '{EN_D2, SEG_G, DWELL_STD};
        end else begin
            dfr[0]   = '{EN_D0, seg_pattern(i_digits.d0), DWELL_STD};
            ndig     = IDX_W'(1);
            minus_fr = '{EN_D1, SEG_G, DWELL_STD};
        end

        if (i_digits.neg) begin
            n_list[0] = minus_fr;
            for (int k = 0; k < 4; k++) begin
                n_list[k+1] = dfr[k];
            end
            n_cnt = ndig + IDX_W'(1);
        end else begin
            for (int k = 0; k < 4; k++) begin
                n_list[k] = dfr[k];
            end
            n_list[4] = minus_fr;
            n_cnt     = ndig;
        end
    end

    assign o_valid  = r_busy;
    assign o_frame  = r_frame[r_idx];
    assign o_last   = (r_idx == r_cnt - IDX_W'(1));
    assign out_take = r_busy && !i_stall;
    assign o_ready  = !r_busy || (out_take && o_last);
    assign load     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_cnt  <= IDX_W'(1);
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_cnt  <= n_cnt;
        end else if (out_take) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_frame[k] <= n_list[k];
            end
        end
    end

endmodule

/* rtl/signed_four_digit_segment_scan.sv */
// ----------------------------------------------------------------------------
// signed_four_digit_segment_scan: scan frames for a signed 4-digit display
// Turns one signed 16-bit value into the frames of one display scan pass.
// ----------------------------------------------------------------------------
// Pipeline: the first frame of a request passes the magnitude stage, three
//   decade stages, then the frame emitter register before it is valid.
// Flow: the emitter drives one frame per cycle while i_stall is low and takes
//   the next request as a last frame goes; the decade pipeline refills behind.
// Reset: synchronous, active low; clears the stage valid bits and emitter
//   state only. No clearing pass, the block takes requests right after reset.
module signed_four_digit_segment_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_digit_enable,
    output logic [6:0]         o_segments,
    output logic [9:0]         o_dwell_ms,
    output logic               o_last
);
    import sdscan_pkg::*;

    // Stage 1: sign and magnitude.
    logic        r1_valid;
    logic        r1_neg;
    logic        r1_big;
    logic [13:0] r1_rem;
    // Stage 2: thousands digit.
    logic        r2_valid;
    logic        r2_neg;
    logic        r2_big;
    logic [3:0]  r2_d3;
    logic [9:0]  r2_rem;
    // Stage 3: hundreds digit.
    logic        r3_valid;
    logic        r3_neg;
    logic        r3_big;
    logic [3:0]  r3_d3;
    logic [3:0]  r3_d2;
    logic [6:0]  r3_rem;
    // Stage 4: tens and ones.
    logic        r4_valid;
    t_digits     r4_digits;

    logic        rdy1, rdy2, rdy3, rdy4;
    logic [15:0] raw;
    logic [15:0] mag;
    logic        n1_neg;
    logic [3:0]  n2_d3;
    logic [3:0]  n3_d2;
    logic [3:0]  n4_d1;
    t_frame      out_frame;

    // Each stage advances when empty or when the stage below takes its item.
    assign rdy3    = !r4_valid || rdy4;
    assign rdy2    = !r3_valid || rdy3;
    assign rdy1    = !r2_valid || rdy2;
    assign o_stall = r1_valid && !rdy1;

    // Two's complement magnitude; the most negative value gives 32768.
    assign raw    = i_value;
    assign n1_neg = raw[15];
    assign mag    = n1_neg ? (~raw + 16'd1) : raw;

    assign n2_d3 = dec_digit(r1_rem, 14'd1000);
    assign n3_d2 = dec_digit({4'd0, r2_rem}, 14'd100);
    assign n4_d1 = dec_digit({7'd0, r3_rem}, 14'd10);

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r1_valid <= i_valid;
            end
            if (rdy1) begin
                r2_valid <= r1_valid;
            end
            if (rdy2) begin
                r3_valid <= r2_valid;
            end
            if (rdy3) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // Payload: hold while the stage below stalls.
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r1_neg <= n1_neg;
            r1_big <= (mag >= BIG_LIMIT);
            r1_rem <= mag[13:0];
        end
        if (rdy1) begin
            r2_neg <= r1_neg;
            r2_big <= r1_big;
            r2_d3  <= n2_d3;
            r2_rem <= 10'(r1_rem - 14'(n2_d3) * 14'd1000);
        end
        if (rdy2) begin
            r3_neg <= r2_neg;
            r3_big <= r2_big;
            r3_d3  <= r2_d3;
            r3_d2  <= n3_d2;
            r3_rem <= 7'(r2_rem - 10'(n3_d2) * 10'd100);
        end
        if (rdy3) begin
            r4_digits.neg <= r3_neg;
            r4_digits.big <= r3_big;
            r4_digits.d3  <= r3_d3;
            r4_digits.d2  <= r3_d2;
            r4_digits.d1  <= n4_d1;
            r4_digits.d0  <= 4'(r3_rem - 7'(n4_d1) * 7'd10);
        end
    end

    // Expand into frames and drive them out one per cycle unless the receiver stalls.
    sdscan_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r4_valid),
        .i_digits (r4_digits),
        .o_ready  (rdy4),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_frame  (out_frame),
        .o_last   (o_last)
    );

    assign o_digit_enable = out_frame.digit_enable;
    assign o_segments     = out_frame.segments;
    assign o_dwell_ms     = out_frame.dwell_ms;

    // A pass is never cut short: after a non-final frame goes, another follows.
    a_pass_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("scan pass broken before its last frame");

    // Blink frames always light every digit.
    a_blink_all_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_dwell_ms == DWELL_BLINK) |-> (o_digit_enable == EN_ALL))
        else $error("blink frame without all digits selected");

    // A selected digit with no segments lit occurs only as the blink-off frame.
    a_blank_only_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_segments == SEG_BLANK) && (o_digit_enable != EN_NONE)
        |-> (o_dwell_ms == DWELL_BLINK) && o_last)
        else $error("selected digit with blank segments outside blink pair");

    // The stage feeding the emitter only moves when the emitter takes it.
    a_emit_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_valid && !rdy4 |=> r4_valid && $stable(r4_digits))
        else $error("decoded value lost while emitter busy");

endmodule

/* dv/tb_signed_four_digit_segment_scan.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_four_digit_segment_scan: self-checking bench for the scan block
// Sends signed display values under random sender gaps and receiver stalls,
// predicts the scan frames of each request and compares every frame in order.
// ----------------------------------------------------------------------------

import sdscan_pkg::*;

typedef struct packed {
    logic [3:0] digit_enable;
    logic [6:0] segments;
    logic [9:0] dwell_ms;
    logic       last;
} t_scan_frame;

class scan_scoreboard;
    t_scan_frame frames_due[$];
    int unsigned mismatches;
    int unsigned requests_seen;
    int unsigned frames_seen;
    int unsigned negatives_seen;
    int unsigned blinks_seen;

    function new();
        mismatches     = 0;
        requests_seen  = 0;
        frames_seen    = 0;
        negatives_seen = 0;
        blinks_seen    = 0;
    endfunction

    function int pending();
        return frames_due.size();
    endfunction

    function logic [6:0] glyph_of(input int digit);
        case (digit)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h27;
            8:       return 7'h7F;
            default: return 7'h6F;
        endcase
    endfunction

    function t_scan_frame make_frame(input logic [3:0] en, input logic [6:0] seg,
                                     input logic [9:0] dwell);
        t_scan_frame f;
        f.digit_enable = en;
        f.segments     = seg;
        f.dwell_ms     = dwell;
        f.last         = 1'b0;
        return f;
    endfunction

    // Expand one accepted value into the frames of its scan pass.
    function void note_request(input logic signed [15:0] value);
        t_scan_frame pass[$];
        t_scan_frame tail;
        int          mag;
        mag = (value < 0) ? -int'(value) : int'(value);
        requests_seen++;
        if (value < 0) begin
            negatives_seen++;
            // Sign sits just left of the top digit; no room left at 1000 and up.
            if (mag < 10)
                pass.push_back(make_frame(EN_D1, SEG_G, DWELL_STD));
            else if (mag < 100)
                pass.push_back(make_frame(EN_D2, SEG_G, DWELL_STD));
            else if (mag < 1000)
                pass.push_back(make_frame(EN_D3, SEG_G, DWELL_STD));
            else
                pass.push_back(make_frame(EN_NONE, SEG_BLANK, DWELL_STD));
        end
        if (mag < 10) begin
            pass.push_back(make_frame(EN_D0, glyph_of(mag), DWELL_STD));
        end else if (mag < 100) begin
            pass.push_back(make_frame(EN_D1, glyph_of(mag / 10), DWELL_STD));
            pass.push_back(make_frame(EN_D0, glyph_of(mag % 10), DWELL_STD));
        end else if (mag < 1000) begin
            pass.push_back(make_frame(EN_D2, glyph_of(mag / 100), DWELL_LEAD));
            pass.push_back(make_frame(EN_D1, glyph_of((mag % 100) / 10), DWELL_TAIL));
            pass.push_back(make_frame(EN_D0, glyph_of(mag % 10), DWELL_TAIL));
        end else if (mag < 10000) begin
            pass.push_back(make_frame(EN_D3, glyph_of(mag / 1000), DWELL_STD));
            pass.push_back(make_frame(EN_D2, glyph_of((mag % 1000) / 100), DWELL_STD));
            pass.push_back(make_frame(EN_D1, glyph_of((mag % 100) / 10), DWELL_STD));
            pass.push_back(make_frame(EN_D0, glyph_of(mag % 10), DWELL_STD));
        end else begin
            blinks_seen++;
            pass.push_back(make_frame(EN_ALL, SEG_G, DWELL_BLINK));
            pass.push_back(make_frame(EN_ALL, SEG_BLANK, DWELL_BLINK));
        end
        tail      = pass.pop_back();
        tail.last = 1'b1;
        pass.push_back(tail);
        foreach (pass[i]) frames_due.push_back(pass[i]);
    endfunction

    function void check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, exp_val, got_val);
        end
    endfunction

    // Compare one accepted frame with the oldest frame still due.
    function void check_frame(input t_scan_frame got);
        t_scan_frame exp_frame;
        frames_seen++;
        if (frames_due.size() == 0) begin
            mismatches++;
            $display("%0t: frame with nothing due, expected none,",
                     $time);
            $display("    got en=%h seg=%h dwell=%0d last=%b",
                     got.digit_enable, got.segments, got.dwell_ms, got.last);
            return;
        end
        exp_frame = frames_due.pop_front();
        check_field("digit_enable", exp_frame.digit_enable, got.digit_enable);
        check_field("segments", exp_frame.segments, got.segments);
        check_field("dwell_ms", exp_frame.dwell_ms, got.dwell_ms);
        check_field("last", exp_frame.last, got.last);
    endfunction
endclass

module tb_signed_four_digit_segment_scan;

    // Quiet cycles tolerated before the run is declared hung; covers the worst
    // stall streak at 67 percent by a wide margin plus the pipeline latency.
    localparam int QUIET_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PER_PHASE = 109;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [15:0] i_value = '0;
    logic               o_stall;
    logic               o_valid;
    logic [3:0]         o_digit_enable;
    logic [6:0]         o_segments;
    logic [9:0]         o_dwell_ms;
    logic               o_last;

    scan_scoreboard sb;
    int             send_idle_pct = 25;
    int             recv_idle_pct = 67;
    int             quiet_cycles  = 0;

    logic signed [15:0] directed_values[$] = '{
        0, 1, -1, 9, -9, 10, -10, 99, -99, 100, -100, 777, -999,
        1000, -1000, 9999, -9999, 10000, -10000, 32767, -32768,
        21845, -21846, 4086
    };

    signed_four_digit_segment_scan dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digit_enable (o_digit_enable),
        .o_segments     (o_segments),
        .o_dwell_ms     (o_dwell_ms),
        .o_last         (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Stall the frame side at the current phase's rate.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Sample both handshakes at the edge; note requests, check frames, and
    // count cycles in which nothing moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_value);
            if (o_valid && !i_stall)
                sb.check_frame('{o_digit_enable, o_segments, o_dwell_ms, o_last});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one request, idling first at random, and hold it until accepted.
    task automatic send_value(input logic signed [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every due frame has been seen.
    task automatic drain_frames();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Pick a magnitude class evenly so every digit count and the blink case
    // show up often; the last class is raw 16-bit noise for bit coverage.
    function automatic logic signed [15:0] random_value();
        int mag;
        case ($urandom_range(5))
            0:       mag = $urandom_range(9, 0);
            1:       mag = $urandom_range(99, 10);
            2:       mag = $urandom_range(999, 100);
            3:       mag = $urandom_range(9999, 1000);
            4:       mag = $urandom_range(32767, 10000);
            default: return 16'($urandom);
        endcase
        if ($urandom_range(1) == 1) mag = -mag;
        return 16'(mag);
    endfunction

    task automatic random_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_value(random_value());
            // Pause once mid-phase until the pipeline is empty.
            if (i == RANDOM_PER_PHASE / 2) drain_frames();
        end
        drain_frames();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: zero, each digit count, both signs, the blank
        // minus frame, the blink pair and the most negative value.
        foreach (directed_values[i]) send_value(directed_values[i]);
        drain_frames();

        random_phase(25, 67);
        random_phase(67, 25);
        random_phase(0, 0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d negative, %0d overflow) and %0d frames",
                 sb.requests_seen, sb.negatives_seen, sb.blinks_seen, sb.frames_seen);
        $display("under three sender/receiver stall mixes; %0d mismatches, %0d frames left",
                 sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/sdscan_pkg.sv
rtl/sdscan_emit.sv
rtl/signed_four_digit_segment_scan.sv
dv/tb_signed_four_digit_segment_scan.sv
